[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cmri_pkg.sv]
// ---------------------------------------------------------------------------
// cmri_pkg
// Shared constants, codes and controller/datapath types of the node frame
// engine.
// ---------------------------------------------------------------------------
package cmri_pkg;

  // Protocol characters.
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_DLE = 8'h10;
  localparam logic [7:0] CH_SYN = 8'h16;

  // Frame type characters.
  localparam logic [7:0] CH_TYPE_I = 8'h49;
  localparam logic [7:0] CH_TYPE_P = 8'h50;
  localparam logic [7:0] CH_TYPE_R = 8'h52;
  localparam logic [7:0] CH_TYPE_T = 8'h54;

  localparam logic [7:0] ADDR_BIAS    = 8'd65;
  localparam logic [6:0] ADDR_MAX     = 7'd64;
  localparam int         STORE_DEPTH  = 8;
  localparam logic [3:0] MAX_PORT_BYTES = 4'd8;
  localparam int         BUF_SIZE_DEF = 64;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_BYTES       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_BYTES      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_INPUTS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_OUTPUTS = 3'd4;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_RESP    = 3'd0,
    EV_OUTPUTS = 3'd1,
    EV_DELAY   = 3'd2,
    EV_ERROR   = 3'd3,
    EV_FOREIGN = 3'd4
  } event_e;

  // What one parsed byte produces.
  typedef enum logic [1:0] {
    RK_NONE,
    RK_ONE,
    RK_POLL
  } result_kind_e;

  typedef struct packed {
    logic take;       // latch the accepted word
    logic commit;     // apply the parse step of the latched word
    logic load;       // load the output register
    logic load_resp;  // load it from the response generator
    logic advance;    // step the response generator
  } ctrl_cmd_t;

  typedef struct packed {
    result_kind_e kind;
    logic         resp_last;
  } dp_stat_t;

endpackage

[rtl/cmri_if.sv]
// ---------------------------------------------------------------------------
// cmri_in_if / cmri_out_if
// Valid/ready channels carrying received words and result words.
// ---------------------------------------------------------------------------
interface cmri_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [63:0] input_pins;

  modport source (output valid, output rx_byte, output input_pins, input ready);
  modport sink (input valid, input rx_byte, input input_pins, output ready);
endinterface

interface cmri_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  tx_byte;
  logic        last_of_response;
  logic [63:0] output_bits;
  logic [19:0] char_delay_us;

  modport source (output valid, output event_res, output tx_byte,
                  output last_of_response, output output_bits,
                  output char_delay_us, input ready);
  modport sink (input valid, input event_res, input tx_byte,
                input last_of_response, input output_bits,
                input char_delay_us, output ready);
endinterface

[rtl/cmri_node_frame_engine.sv]
// ---------------------------------------------------------------------------
// cmri_node_frame_engine
// Node side of a serial railroad I/O frame protocol: parses host bytes,
// drives output ports, sets the character delay and answers polls.
// ---------------------------------------------------------------------------
//  Channel   Dir  Contents
//  rx_i      in   rx_byte, input_pins (one received byte with pin sample)
//  tx_o      out  event_res, tx_byte, last_of_response, output_bits,
//                 char_delay_us
//  cfg_*     in   write enable, register index, write data
//
// A word is latched when taken and parsed from that latch in the work state;
// no word is taken until that parse step is done. The ETX of a poll frame
// starts a response burst of up to 22 words at one word per cycle while the
// output register is free, during which no input word is taken. Words that
// produce a result wait in the parse step only when the output register is
// still full; an output word may sit unclaimed while the next input word is
// accepted. Reset clears the parser, the configuration and the character
// delay; the eight-byte data store holds no reset value, and only bytes
// received in the current frame are ever read from it.
// ---------------------------------------------------------------------------
module cmri_node_frame_engine #(
  parameter int BUF_SIZE = cmri_pkg::BUF_SIZE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cmri_in_if.sink                         rx_i,
  cmri_out_if.source                      tx_o,
  input  logic                            cfg_we_i,
  input  logic [cmri_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cmri_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cmri_pkg::ctrl_cmd_t cmd;
  cmri_pkg::dp_stat_t  stat;

  // The controller owns the handshakes and the sequence of steps; the
  // datapath holds every register that carries frame or payload data.
  cmri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_ready_o  (rx_i.ready),
    .out_valid_o (tx_o.valid),
    .out_ready_i (tx_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cmri_dp #(
    .BUF_SIZE (BUF_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .rx_byte_i    (rx_i.rx_byte),
    .input_pins_i (rx_i.input_pins),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .event_o      (tx_o.event_res),
    .tx_byte_o    (tx_o.tx_byte),
    .last_o       (tx_o.last_of_response),
    .bits_o       (tx_o.output_bits),
    .delay_o      (tx_o.char_delay_us)
  );

endmodule

[rtl/cmri_dp.sv]
// ---------------------------------------------------------------------------
// cmri_dp
// Datapath: configuration registers, frame parser state, data store,
// poll response generator and the output word register.
// ---------------------------------------------------------------------------
module cmri_dp #(
  parameter int BUF_SIZE = cmri_pkg::BUF_SIZE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cmri_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cmri_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic [63:0]                     input_pins_i,
  input  cmri_pkg::ctrl_cmd_t             cmd_i,
  output cmri_pkg::dp_stat_t              stat_o,
  output logic [2:0]                      event_o,
  output logic [7:0]                      tx_byte_o,
  output logic                            last_o,
  output logic [63:0]                     bits_o,
  output logic [19:0]                     delay_o
);

  localparam int CNT_W = $clog2(BUF_SIZE + 2);

  typedef enum logic [2:0] {
    PH_HUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_FLUSH
  } phase_e;

  typedef enum logic [1:0] {
    FT_I, FT_P, FT_R, FT_T
  } ftype_e;

  // Configuration.
  logic [6:0] node_addr_q;
  logic [3:0] in_bytes_q, out_bytes_q;
  logic       inv_in_q, inv_out_q;

  // Parser state.
  phase_e           phase_q, phase_d;
  ftype_e           ftype_q, ftype_d;
  logic             esc_q, esc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [19:0]      delay_q, delay_d;
  logic [7:0]       store_q [cmri_pkg::STORE_DEPTH];
  logic             store_we;

  // Latched input word.
  logic [7:0]  rx_q;
  logic [63:0] pins_q;

  // Response generator.
  logic [2:0] hdr_q;
  logic [3:0] pj_q;
  logic       dle_q;

  cmri_pkg::result_kind_e kind;
  cmri_pkg::event_e       ev;
  logic [7:0]             addr_match;
  logic [3:0]             in_cnt, out_cnt;
  logic [7:0]             d1, d2;
  logic [15:0]            dword;
  logic [63:0]            t_bits;
  logic [7:0]             resp_byte, pin_byte;
  logic                   pin_esc, resp_last;

  assign addr_match = ((node_addr_q > cmri_pkg::ADDR_MAX) ? {1'b0, cmri_pkg::ADDR_MAX}
                                                          : {1'b0, node_addr_q})
                      + cmri_pkg::ADDR_BIAS;
  assign in_cnt  = (in_bytes_q > cmri_pkg::MAX_PORT_BYTES) ? cmri_pkg::MAX_PORT_BYTES
                                                           : in_bytes_q;
  assign out_cnt = (out_bytes_q > cmri_pkg::MAX_PORT_BYTES) ? cmri_pkg::MAX_PORT_BYTES
                                                            : out_bytes_q;

  // Bytes beyond those received read as zero.
  assign d1    = (cnt_q > CNT_W'(1)) ? store_q[1] : 8'h00;
  assign d2    = (cnt_q > CNT_W'(2)) ? store_q[2] : 8'h00;
  assign dword = {d1, d2};

  always_comb begin
    for (int j = 0; j < cmri_pkg::STORE_DEPTH; j++) begin
      if ((CNT_W'(j) < cnt_q) && (4'(j) < out_cnt)) begin
        t_bits[8*j +: 8] = store_q[j] ^ {8{inv_out_q}};
      end else if (4'(j) < out_cnt) begin
        t_bits[8*j +: 8] = {8{inv_out_q}};
      end else begin
        t_bits[8*j +: 8] = 8'h00;
      end
    end
  end

  // Parse step for the latched word.
  always_comb begin
    phase_d  = phase_q;
    ftype_d  = ftype_q;
    esc_d    = esc_q;
    cnt_d    = cnt_q;
    delay_d  = delay_q;
    store_we = 1'b0;
    kind     = cmri_pkg::RK_NONE;
    ev       = cmri_pkg::EV_ERROR;
    case (phase_q)
      PH_HUNT: begin
        if (rx_q == cmri_pkg::CH_STX) begin
          phase_d = PH_ADDR;
        end
      end
      PH_ADDR: begin
        esc_d = 1'b0;
        if (rx_q == addr_match) begin
          phase_d = PH_TYPE;
        end else begin
          phase_d = PH_FLUSH;
          kind    = cmri_pkg::RK_ONE;
          ev      = cmri_pkg::EV_FOREIGN;
        end
      end
      PH_TYPE: begin
        cnt_d   = '0;
        esc_d   = 1'b0;
        phase_d = PH_DATA;
        case (rx_q)
          cmri_pkg::CH_TYPE_I: ftype_d = FT_I;
          cmri_pkg::CH_TYPE_P: ftype_d = FT_P;
          cmri_pkg::CH_TYPE_R: ftype_d = FT_R;
          cmri_pkg::CH_TYPE_T: ftype_d = FT_T;
          default: begin
            phase_d = PH_FLUSH;
            kind    = cmri_pkg::RK_ONE;
            ev      = cmri_pkg::EV_ERROR;
          end
        endcase
      end
      PH_DATA: begin
        if (esc_q) begin
          esc_d    = 1'b0;
          store_we = 1'b1;
        end else if (rx_q == cmri_pkg::CH_DLE) begin
          esc_d = 1'b1;
        end else if (rx_q == cmri_pkg::CH_STX) begin
          phase_d = PH_ADDR;
        end else if (rx_q == cmri_pkg::CH_ETX) begin
          phase_d = PH_HUNT;
          case (ftype_q)
            FT_I: begin
              delay_d = {1'b0, dword, 3'b000} + {3'b000, dword, 1'b0};
              kind    = cmri_pkg::RK_ONE;
              ev      = cmri_pkg::EV_DELAY;
            end
            FT_T: begin
              kind = cmri_pkg::RK_ONE;
              ev   = cmri_pkg::EV_OUTPUTS;
            end
            FT_P:    kind = cmri_pkg::RK_POLL;
            default: kind = cmri_pkg::RK_NONE;
          endcase
        end else begin
          store_we = 1'b1;
        end
        if (store_we) begin
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_q >= CNT_W'(BUF_SIZE)) begin
            phase_d = PH_FLUSH;
            esc_d   = 1'b0;
            kind    = cmri_pkg::RK_ONE;
            ev      = cmri_pkg::EV_ERROR;
          end
        end
      end
      default: begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (rx_q == cmri_pkg::CH_DLE) begin
          esc_d = 1'b1;
        end else if (rx_q == cmri_pkg::CH_ETX) begin
          phase_d = PH_HUNT;
        end
      end
    endcase
  end

  // Poll response byte selection.
  assign pin_byte  = pins_q[8*pj_q[2:0] +: 8] ^ {8{inv_in_q}};
  assign pin_esc   = pin_byte inside {cmri_pkg::CH_STX, cmri_pkg::CH_ETX, cmri_pkg::CH_DLE};
  assign resp_last = (hdr_q == 3'd5) && (pj_q >= in_cnt);

  always_comb begin
    case (hdr_q)
      3'd0, 3'd1: resp_byte = cmri_pkg::CH_SYN;
      3'd2:       resp_byte = cmri_pkg::CH_STX;
      3'd3:       resp_byte = addr_match;
      3'd4:       resp_byte = cmri_pkg::CH_TYPE_R;
      default: begin
        if (resp_last) begin
          resp_byte = cmri_pkg::CH_ETX;
        end else if (pin_esc && !dle_q) begin
          resp_byte = cmri_pkg::CH_DLE;
        end else begin
          resp_byte = pin_byte;
        end
      end
    endcase
  end

  assign stat_o.kind      = kind;
  assign stat_o.resp_last = resp_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q <= '0;
      in_bytes_q  <= '0;
      out_bytes_q <= '0;
      inv_in_q    <= 1'b0;
      inv_out_q   <= 1'b0;
      phase_q     <= PH_HUNT;
      ftype_q     <= FT_I;
      esc_q       <= 1'b0;
      cnt_q       <= '0;
      delay_q     <= '0;
      hdr_q       <= '0;
      pj_q        <= '0;
      dle_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cmri_pkg::CFG_NODE_ADDRESS:   node_addr_q <= cfg_data_i;
          cmri_pkg::CFG_IN_BYTES:       in_bytes_q  <= cfg_data_i[3:0];
          cmri_pkg::CFG_OUT_BYTES:      out_bytes_q <= cfg_data_i[3:0];
          cmri_pkg::CFG_INVERT_INPUTS:  inv_in_q    <= cfg_data_i[0];
          cmri_pkg::CFG_INVERT_OUTPUTS: inv_out_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        phase_q <= phase_d;
        ftype_q <= ftype_d;
        esc_q   <= esc_d;
        cnt_q   <= cnt_d;
        delay_q <= delay_d;
        if (kind == cmri_pkg::RK_POLL) begin
          hdr_q <= '0;
          pj_q  <= '0;
          dle_q <= 1'b0;
        end
      end
      if (cmd_i.advance) begin
        if (hdr_q != 3'd5) begin
          hdr_q <= hdr_q + 3'd1;
        end else if (!resp_last) begin
          if (pin_esc && !dle_q) begin
            dle_q <= 1'b1;
          end else begin
            dle_q <= 1'b0;
            pj_q  <= pj_q + 4'd1;
          end
        end
      end
    end
  end

  // Payload registers: data store, latched word and output word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && store_we && (cnt_q < CNT_W'(cmri_pkg::STORE_DEPTH))) begin
      store_q[cnt_q[2:0]] <= rx_q;
    end
    if (cmd_i.take) begin
      rx_q   <= rx_byte_i;
      pins_q <= input_pins_i;
    end
    if (cmd_i.load) begin
      if (cmd_i.load_resp) begin
        event_o   <= cmri_pkg::EV_RESP;
        tx_byte_o <= resp_byte;
        last_o    <= resp_last;
        bits_o    <= '0;
        delay_o   <= delay_q;
      end else begin
        event_o   <= ev;
        tx_byte_o <= 8'h00;
        last_o    <= 1'b0;
        bits_o    <= (ev == cmri_pkg::EV_OUTPUTS) ? t_bits : 64'h0;
        delay_o   <= delay_d;
      end
    end
  end

endmodule

[rtl/cmri_ctrl.sv]
// ---------------------------------------------------------------------------
// cmri_ctrl
// Controller: sequences word intake, the parse step, the poll response
// burst and the output register's valid flag.
// ---------------------------------------------------------------------------
module cmri_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  cmri_pkg::dp_stat_t  stat_i,
  output cmri_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE, ST_WORK, ST_POLL
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_WORK;
        end
      end
      ST_WORK: begin
        case (stat_i.kind)
          cmri_pkg::RK_ONE: begin
            if (out_free) begin
              cmd_o.commit = 1'b1;
              cmd_o.load   = 1'b1;
              out_valid_d  = 1'b1;
              state_d      = ST_IDLE;
            end
          end
          cmri_pkg::RK_POLL: begin
            cmd_o.commit = 1'b1;
            state_d      = ST_POLL;
          end
          default: begin
            cmd_o.commit = 1'b1;
            state_d      = ST_IDLE;
          end
        endcase
      end
      ST_POLL: begin
        if (out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.load_resp = 1'b1;
          cmd_o.advance   = 1'b1;
          out_valid_d     = 1'b1;
          if (stat_i.resp_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/cmri_chk.sv]
// ---------------------------------------------------------------------------
// cmri_chk
// Port-level checker for the node frame engine, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cmri_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  event_i,
  input logic [7:0]  tx_byte_i,
  input logic        last_i,
  input logic [63:0] bits_i
);

  // A stalled output word stays valid and keeps its event, byte and output bits.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(event_i) && $stable(tx_byte_i) && $stable(bits_i), "stalled output word changed")

  // The input is not ready in the cycle after a word is taken, while it is parsed.
  `ASSERT_NEXT(a_in_gap, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input taken in the parse cycle")

  // The response end marker only rides on a closing ETX.
  `ASSERT_IMPLY(a_last_etx, clk_i, rst_ni, out_valid_i && last_i, (event_i == cmri_pkg::EV_RESP) && (tx_byte_i == cmri_pkg::CH_ETX), "last flag on a non-ETX word")

  // Event words carry no response byte.
  `ASSERT_IMPLY(a_event_clean, clk_i, rst_ni, out_valid_i && (event_i != cmri_pkg::EV_RESP), (tx_byte_i == 8'h00) && !last_i, "event word with a response byte")

  // Output bits appear only on an output update.
  `ASSERT_IMPLY(a_bits_zero, clk_i, rst_ni, out_valid_i && (event_i != cmri_pkg::EV_OUTPUTS), bits_i == 64'h0, "output bits on a non-update word")

endmodule

bind cmri_node_frame_engine cmri_chk u_cmri_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rx_i.valid),
  .in_ready_i  (rx_i.ready),
  .out_valid_i (tx_o.valid),
  .out_ready_i (tx_o.ready),
  .event_i     (tx_o.event_res),
  .tx_byte_i   (tx_o.tx_byte),
  .last_i      (tx_o.last_of_response),
  .bits_i      (tx_o.output_bits)
);

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb: self-checking testbench of the serial node frame engine
// Feeds host bytes framed as STX, address, type, escaped data and ETX through
// the receive channel, predicts every result word from a software copy of
// the frame parser, and compares the transmit channel word by word. Both
// channels idle at random, and the receiver once holds off long enough to
// back the engine up into its input.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmri_pkg::*;

  localparam int FRAME_BUF   = BUF_SIZE_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 30;     // covers a full response burst and then some
  localparam int HOLD_AT     = 80;     // words taken before the long receiver hold-off
  localparam int HOLD_LEN    = 400;    // cycles of that hold-off
  localparam int MAX_REPORTS = 40;
  localparam int PHASE_WORDS = 35;     // random words queued per configuration

  // Parser states and frame kinds of the predictor.
  typedef enum logic [2:0] {
    PS_HUNT, PS_ADDR, PS_TYPE, PS_DATA, PS_FLUSH
  } parse_state_e;

  typedef enum logic [1:0] {
    FR_I, FR_P, FR_R, FR_T
  } frame_kind_e;

  // One host word: the received byte and the pin sample that travels with it.
  typedef struct {
    logic [7:0]  rx;
    logic [63:0] pins;
  } host_word_t;

  // One result word as the transmit channel carries it.
  typedef struct {
    event_e      ev;
    logic [7:0]  tx;
    logic        last;
    logic [63:0] bits;
    logic [19:0] delay;
  } node_result_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  cmri_in_if  rx_if ();
  cmri_out_if tx_if ();

  cmri_node_frame_engine #(
    .BUF_SIZE (FRAME_BUF)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_if),
    .tx_o       (tx_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Host words still to be offered, and result words still owed by the engine.
  host_word_t   host_words[$];
  node_result_t expected_words[$];

  // Copy of the configuration registers, updated as each write lands.
  logic [6:0] node_num;
  logic [3:0] in_count;
  logic [3:0] out_count;
  logic       inv_in;
  logic       inv_out;

  // Copy of the parser state.
  parse_state_e pstate;
  frame_kind_e  fkind;
  logic         esc_pend;
  logic [7:0]   frame_data[STORE_DEPTH];
  int           frame_len;
  logic [19:0]  delay_us;

  int fail_count;
  int cycle_count;
  bit quiet;          // set for the tail of the run: no idling on either side
  int queued;

  int           send_gap;
  int           recv_gap;
  int           words_seen;
  int           hold_left;
  bit           hold_done;
  node_result_t want;

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // Address byte this node answers to; node numbers above the top act as it.
  function automatic logic [7:0] own_addr();
    return ((node_num > ADDR_MAX) ? ADDR_MAX : node_num) + ADDR_BIAS;
  endfunction

  function automatic bit is_ctrl(input logic [7:0] b);
    return (b == CH_STX) || (b == CH_ETX) || (b == CH_DLE);
  endfunction

  // Data bytes past those received in this frame, or past the store, read as zero.
  function automatic logic [7:0] frame_byte(input int i);
    return (i < frame_len && i < STORE_DEPTH) ? frame_data[i] : 8'h00;
  endfunction

  function automatic void owe_word(input event_e ev, input logic [7:0] tx,
                                   input logic last, input logic [63:0] bits);
    node_result_t r;
    r.ev    = ev;
    r.tx    = tx;
    r.last  = last;
    r.bits  = bits;
    r.delay = delay_us;
    expected_words.push_back(r);
  endfunction

  // The closing ETX of a frame: act on its type.
  function automatic void close_frame(input logic [63:0] pins);
    int         j;
    int         cnt;
    int         d;
    logic [7:0] v;
    logic [63:0] bits;
    case (fkind)
      FR_I: begin
        d = (int'(frame_byte(1)) * 256 + int'(frame_byte(2))) * 10;
        delay_us = d[19:0];
        owe_word(EV_DELAY, 8'h00, 1'b0, 64'h0);
      end
      FR_T: begin
        bits = 64'h0;
        cnt = (out_count > MAX_PORT_BYTES) ? MAX_PORT_BYTES : out_count;
        for (j = 0; j < cnt; j++) begin
          v = frame_byte(j) ^ {8{inv_out}};
          bits[8*j +: 8] = v;
        end
        owe_word(EV_OUTPUTS, 8'h00, 1'b0, bits);
      end
      FR_P: begin
        // Poll response: SYN SYN STX addr 'R', stuffed input bytes, ETX.
        owe_word(EV_RESP, CH_SYN, 1'b0, 64'h0);
        owe_word(EV_RESP, CH_SYN, 1'b0, 64'h0);
        owe_word(EV_RESP, CH_STX, 1'b0, 64'h0);
        owe_word(EV_RESP, own_addr(), 1'b0, 64'h0);
        owe_word(EV_RESP, CH_TYPE_R, 1'b0, 64'h0);
        cnt = (in_count > MAX_PORT_BYTES) ? MAX_PORT_BYTES : in_count;
        for (j = 0; j < cnt; j++) begin
          v = pins[8*j +: 8] ^ {8{inv_in}};
          if (is_ctrl(v))
            owe_word(EV_RESP, CH_DLE, 1'b0, 64'h0);
          owe_word(EV_RESP, v, 1'b0, 64'h0);
        end
        owe_word(EV_RESP, CH_ETX, 1'b1, 64'h0);
      end
      default: ;  // R frames are ignored
    endcase
  endfunction

  // One accepted host word through the parser; owed results are queued.
  function automatic void parse_rx_word(input logic [7:0] rx, input logic [63:0] pins);
    bit keep;
    keep = 1'b0;
    case (pstate)
      PS_HUNT: begin
        // Anything before STX, SYN and control bytes included, is dropped.
        if (rx == CH_STX)
          pstate = PS_ADDR;
      end
      PS_ADDR: begin
        esc_pend = 1'b0;
        if (rx == own_addr()) begin
          pstate = PS_TYPE;
        end else begin
          pstate = PS_FLUSH;
          owe_word(EV_FOREIGN, 8'h00, 1'b0, 64'h0);
        end
      end
      PS_TYPE: begin
        frame_len = 0;
        esc_pend  = 1'b0;
        pstate    = PS_DATA;
        case (rx)
          CH_TYPE_I: fkind = FR_I;
          CH_TYPE_P: fkind = FR_P;
          CH_TYPE_R: fkind = FR_R;
          CH_TYPE_T: fkind = FR_T;
          default: begin
            pstate = PS_FLUSH;
            owe_word(EV_ERROR, 8'h00, 1'b0, 64'h0);
          end
        endcase
      end
      PS_DATA: begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          keep = 1'b1;
        end else if (rx == CH_DLE) begin
          esc_pend = 1'b1;
        end else if (rx == CH_STX) begin
          // An unescaped STX restarts the header; data so far is dropped.
          pstate = PS_ADDR;
        end else if (rx == CH_ETX) begin
          pstate = PS_HUNT;
          close_frame(pins);
        end else begin
          keep = 1'b1;
        end
        if (keep) begin
          if (frame_len < STORE_DEPTH)
            frame_data[frame_len] = rx;
          frame_len++;
          if (frame_len > FRAME_BUF) begin
            pstate   = PS_FLUSH;
            esc_pend = 1'b0;
            owe_word(EV_ERROR, 8'h00, 1'b0, 64'h0);
          end
        end
      end
      default: begin
        // Discarding up to an unescaped ETX.
        if (esc_pend)
          esc_pend = 1'b0;
        else if (rx == CH_DLE)
          esc_pend = 1'b1;
        else if (rx == CH_ETX)
          pstate = PS_HUNT;
      end
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  function automatic void push_word(input logic [7:0] b, input logic [63:0] pins);
    host_word_t w;
    w.rx   = b;
    w.pins = pins;
    host_words.push_back(w);
    queued++;
  endfunction

  // Pin samples lean toward bytes that need stuffing, plain or inverted.
  function automatic logic [63:0] rand_pins();
    logic [63:0] p;
    int          k;
    p = {$urandom, $urandom};
    for (k = 0; k < 8; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: p[8*k +: 8] = CH_STX;
          1: p[8*k +: 8] = CH_ETX;
          2: p[8*k +: 8] = CH_DLE;
          3: p[8*k +: 8] = ~CH_STX;
          4: p[8*k +: 8] = ~CH_ETX;
          default: p[8*k +: 8] = ~CH_DLE;
        endcase
      end
    end
    return p;
  endfunction

  // A frame with random content. Most are well formed; some carry a foreign
  // address, an unknown type, raw control bytes in the data or no ETX. With
  // overrun set, the frame is well formed but longer than the buffer.
  task automatic queue_frame(input bit overrun);
    int         n;
    int         k;
    logic [7:0] b;
    repeat ($urandom_range(0, 2)) push_word(CH_SYN, rand_pins());
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) push_word(8'($urandom_range(0, 255)), rand_pins());
    push_word(CH_STX, rand_pins());
    if (overrun || $urandom_range(0, 6) != 0)
      push_word(own_addr(), rand_pins());
    else
      push_word(8'($urandom_range(0, 255)), rand_pins());
    if (overrun) begin
      push_word(CH_TYPE_T, rand_pins());
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    push_word(CH_TYPE_I, rand_pins());
        2, 3, 4: push_word(CH_TYPE_P, rand_pins());
        5:       push_word(CH_TYPE_R, rand_pins());
        6, 7, 8: push_word(CH_TYPE_T, rand_pins());
        default: push_word(8'($urandom_range(0, 255)), rand_pins());
      endcase
    end
    if (overrun)
      n = FRAME_BUF + 2;
    else if ($urandom_range(0, 4) == 0)
      n = $urandom_range(9, 12);
    else
      n = $urandom_range(0, 4);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: b = CH_STX;
          1: b = CH_ETX;
          2: b = CH_DLE;
          default: b = CH_SYN;
        endcase
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      if (is_ctrl(b) && (overrun || $urandom_range(0, 5) != 0))
        push_word(CH_DLE, rand_pins());
      push_word(b, rand_pins());
    end
    if (overrun || $urandom_range(0, 15) != 0)
      push_word(CH_ETX, rand_pins());
  endtask

  // Writes all five registers back to back; the copy follows each write edge.
  task automatic set_config(input logic [6:0] node, input logic [3:0] nin,
                            input logic [3:0] nout, input logic iin,
                            input logic iout);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_NODE_ADDRESS;
    cfg_data <= node;
    @(posedge clk_i);
    node_num = node;
    cfg_idx <= CFG_IN_BYTES;
    cfg_data <= CFG_DATA_W'(nin);
    @(posedge clk_i);
    in_count = nin;
    cfg_idx <= CFG_OUT_BYTES;
    cfg_data <= CFG_DATA_W'(nout);
    @(posedge clk_i);
    out_count = nout;
    cfg_idx <= CFG_INVERT_INPUTS;
    cfg_data <= CFG_DATA_W'(iin);
    @(posedge clk_i);
    inv_in = iin;
    cfg_idx <= CFG_INVERT_OUTPUTS;
    cfg_data <= CFG_DATA_W'(iout);
    @(posedge clk_i);
    inv_out = iout;
    cfg_we <= 1'b0;
    // Queue new words away from the rising edge the driver works on.
    @(negedge clk_i);
  endtask

  // Waits until every host word is taken and every owed result has come,
  // then lets the engine finish any word that owes nothing.
  task automatic drain();
    while (host_words.size() != 0 || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic random_phase(input int words);
    queued = 0;
    while (queued < words)
      queue_frame(($urandom_range(0, 39) == 0));
  endtask

  // -------------------------------------------------------------------------
  // Driver: offers the oldest pending host word. A word on offer is held
  // until taken; random idle gaps only start between words.
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid      <= 1'b0;
      rx_if.rx_byte    <= 8'h00;
      rx_if.input_pins <= 64'h0;
      send_gap = 0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        parse_rx_word(rx_if.rx_byte, rx_if.input_pins);
        void'(host_words.pop_front());
      end
      if (rx_if.valid && !rx_if.ready) begin
        // Keep offering the same word.
      end else if (send_gap > 0) begin
        send_gap--;
        rx_if.valid <= 1'b0;
      end else if (host_words.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 4);
        rx_if.valid <= 1'b0;
      end else if (host_words.size() != 0) begin
        rx_if.valid      <= 1'b1;
        rx_if.rx_byte    <= host_words[0].rx;
        rx_if.input_pins <= host_words[0].pins;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // Once, after HOLD_AT words, the receiver is held off while the driver keeps
  // offering, so the engine fills and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_seen <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      if (rx_if.valid && rx_if.ready)
        words_seen <= words_seen + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && words_seen >= HOLD_AT) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: every word taken from the transmit channel is checked against
  // the oldest owed result, field by field (event, byte, last, bits, delay).
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_if.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (tx_if.valid && tx_if.ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected word: expected none, actual %0d %h %b %h %0d",
                     $time, tx_if.event_res, tx_if.tx_byte, tx_if.last_of_response,
                     tx_if.output_bits, tx_if.char_delay_us);
        end else begin
          want = expected_words.pop_front();
          if (tx_if.event_res !== want.ev || tx_if.tx_byte !== want.tx ||
              tx_if.last_of_response !== want.last || tx_if.output_bits !== want.bits ||
              tx_if.char_delay_us !== want.delay) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: mismatch: expected %0d %h %b %h %0d, actual %0d %h %b %h %0d",
                       $time, want.ev, want.tx, want.last, want.bits, want.delay,
                       tx_if.event_res, tx_if.tx_byte, tx_if.last_of_response,
                       tx_if.output_bits, tx_if.char_delay_us);
          end
        end
      end
      if (hold_left != 0) begin
        tx_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        tx_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 4);
        tx_if.ready <= 1'b0;
      end else begin
        tx_if.ready <= 1'b1;
      end
    end
  end

  // A hung engine ends the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sequence of the run.
  // -------------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_NODE_ADDRESS;
    cfg_data         = '0;
    rx_if.valid      = 1'b0;
    rx_if.rx_byte    = 8'h00;
    rx_if.input_pins = 64'h0;
    tx_if.ready      = 1'b0;
    fail_count  = 0;
    cycle_count = 0;
    quiet       = 1'b0;
    queued      = 0;
    node_num  = '0;
    in_count  = '0;
    out_count = '0;
    inv_in    = 1'b0;
    inv_out   = 1'b0;
    pstate    = PS_HUNT;
    fkind     = FR_I;
    esc_pend  = 1'b0;
    frame_len = 0;
    delay_us  = '0;
    for (int i = 0; i < STORE_DEPTH; i++)
      frame_data[i] = 8'h00;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames for node 5, whose address byte is 'F'.
    set_config(7'd5, 4'd8, 4'd8, 1'b0, 1'b0);
    // Stray bytes before any STX are dropped.
    push_word(CH_SYN, 64'h0);
    push_word(CH_ETX, 64'h0);
    // The largest character delay.
    push_word(CH_STX, 64'h0);
    push_word(own_addr(), 64'h0);
    push_word(CH_TYPE_I, 64'h0);
    push_word(8'h00, 64'h0);
    push_word(8'hFF, 64'h0);
    push_word(8'hFF, 64'h0);
    push_word(CH_ETX, 64'h0);
    // Poll with input bytes that need DLE stuffing, plus zero and all ones.
    push_word(CH_STX, 64'h0);
    push_word(own_addr(), 64'h0);
    push_word(CH_TYPE_P, 64'h0);
    push_word(CH_ETX, 64'h100302FF00807F01);
    // Foreign address: one result, then discarded to the ETX.
    push_word(CH_STX, 64'h0);
    push_word(own_addr() + 8'd1, 64'h0);
    push_word(CH_ETX, 64'h0);
    // Unknown type.
    push_word(CH_STX, 64'h0);
    push_word(own_addr(), 64'h0);
    push_word(8'h58, 64'h0);
    push_word(CH_ETX, 64'h0);
    // Short T frame whose one data byte is an escaped ETX; the rest read as zero.
    push_word(CH_STX, 64'h0);
    push_word(own_addr(), 64'h0);
    push_word(CH_TYPE_T, 64'h0);
    push_word(CH_DLE, 64'h0);
    push_word(CH_ETX, 64'h0);
    push_word(CH_ETX, 64'hFFFFFFFFFFFFFFFF);
    drain();

    // Lowest settings: node 0, no port bytes.
    set_config(7'd0, 4'd0, 4'd0, 1'b0, 1'b0);
    random_phase(PHASE_WORDS);
    drain();

    // Highest legal settings with both inversions; the long hold-off lands here.
    set_config(7'd64, 4'd8, 4'd8, 1'b1, 1'b1);
    random_phase(PHASE_WORDS);
    drain();

    // Out-of-range values that clamp, and a guaranteed buffer overrun.
    set_config(7'd127, 4'd15, 4'd15, 1'b0, 1'b1);
    queue_frame(1'b1);
    random_phase(PHASE_WORDS);
    drain();

    // Random legal settings; the tail of this phase runs without idling.
    set_config(7'($urandom_range(0, 64)), 4'($urandom_range(0, 8)),
               4'($urandom_range(0, 8)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    random_phase(PHASE_WORDS);
    while (host_words.size() > 20)
      @(negedge clk_i);
    quiet = 1'b1;
    drain();

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[cmri_node_frame_engine.f]
+incdir+rtl
rtl/cmri_pkg.sv
rtl/cmri_if.sv
rtl/cmri_dp.sv
rtl/cmri_ctrl.sv
rtl/cmri_node_frame_engine.sv
rtl/cmri_chk.sv
tb/tb.sv
